@@ design/multi_tone_fsk_iq_synthesizer_unit_assert.svh @@
// Assertion shorthands for the synthesizer. Every property is sampled on the
// rising edge of i_clk and is switched off while i_rst_n is low.
`ifndef MULTI_TONE_FSK_IQ_SYNTHESIZER_UNIT_ASSERT_SVH
`define MULTI_TONE_FSK_IQ_SYNTHESIZER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MTFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MTFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mtfs_pkg.sv @@
package mtfs_pkg;

    // Structural constants.
    localparam int NUM_TONES      = 6;
    localparam int TOGGLE_PERIOD  = 50;
    localparam int PHASE_BITS     = 24;
    localparam int SINE_ADDR_BITS = 12;

    // Field widths.
    localparam int MODE_W    = 2;
    localparam int IDX_W     = 3;
    localparam int FREQ_W    = 16;
    localparam int AMPL_W    = 12;
    localparam int SAMP_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILED = 1'd1;

    localparam int HALF_WINDOW = 500;

    localparam int TONE_CNT_W = $clog2(NUM_TONES + 1);
    localparam int TONE_IDX_W = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
    localparam int POS_W      = $clog2(2 * TOGGLE_PERIOD);

    localparam int SINE_QTR = 1 << (SINE_ADDR_BITS - 2);

    // Shared multiplier and accumulators.
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 28 + $clog2(NUM_TONES);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(2 ** (SAMP_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO     = ACC_W'(-(2 ** (SAMP_W - 1)));

    // Phase step arithmetic. The divisor 1000 * 2^(32-PHASE_BITS) is split into
    // 125 * 2^STEP_SH. The power of two is taken off exactly, and 2^(PHASE_BITS-3)
    // is written as 125*STEP_A + STEP_B, so that only a small remainder term is
    // divided by 125, through a reciprocal multiply that is exact over its range.
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam longint OFFSET_Q32 = 64'sd49830432770;
    localparam longint DIV_Q      = 125;
    localparam int     STEP_SH    = 35 - PHASE_BITS;
    localparam longint HALF_D     = DIV_Q << (STEP_SH - 1);
    localparam longint STEP_A     = (longint'(1) << (PHASE_BITS - 3)) / DIV_Q;
    localparam longint STEP_B     = (longint'(1) << (PHASE_BITS - 3)) % DIV_Q;
    localparam longint FREQ_MAX   = (longint'(1) << FREQ_W) - 1;
    localparam longint STEP_K     = (STEP_B * FREQ_MAX) / DIV_Q + 1;

    localparam longint C_PLUS  = (HALF_D + OFFSET_Q32) >>> STEP_SH;
    localparam longint C_MINUS = (HALF_D - OFFSET_Q32) >>> STEP_SH;
    localparam longint C_ZERO  = HALF_D >>> STEP_SH;

    localparam longint R_PLUS  = ((C_PLUS % DIV_Q) + DIV_Q) % DIV_Q;
    localparam longint R_MINUS = ((C_MINUS % DIV_Q) + DIV_Q) % DIV_Q;
    localparam longint R_ZERO  = ((C_ZERO % DIV_Q) + DIV_Q) % DIV_Q;

    localparam longint ZADD_PLUS  = R_PLUS + DIV_Q * STEP_K;
    localparam longint ZADD_MINUS = R_MINUS + DIV_Q * STEP_K;
    localparam longint ZADD_ZERO  = R_ZERO + DIV_Q * STEP_K;

    localparam longint SADD_PLUS  = (C_PLUS - R_PLUS) / DIV_Q - STEP_K;
    localparam longint SADD_MINUS = (C_MINUS - R_MINUS) / DIV_Q - STEP_K;
    localparam longint SADD_ZERO  = (C_ZERO - R_ZERO) / DIV_Q - STEP_K;

    localparam int     RECIP_SH = 31;
    localparam longint RECIP_M  = ((longint'(1) << RECIP_SH) + DIV_Q - 1) / DIV_Q;

    // One quarter-wave entry of the Q1.15 sine table, by a truncated Taylor
    // series in Q30. Evaluated at elaboration only.
    function automatic logic [SAMP_W-1:0] quarter_sine(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        int unsigned n;
        x    = (64'(r) * TWO_PI_Q30) >> SINE_ADDR_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return SAMP_W'((sum * 32767 + (longint'(1) << 29)) >>> 30);
    endfunction

endpackage

@@ design/mtfs_in_if.sv @@
interface mtfs_in_if;
    import mtfs_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  tone_index;
    logic [FREQ_W-1:0] tone_freq;
    logic [AMPL_W-1:0] tone_ampl;

    modport source (
        output valid, mode, tone_index, tone_freq, tone_ampl,
        input  ready
    );

    modport sink (
        input  valid, mode, tone_index, tone_freq, tone_ampl,
        output ready
    );
endinterface

@@ design/mtfs_out_if.sv @@
interface mtfs_out_if;
    import mtfs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     status;
    logic signed [SAMP_W-1:0] i_sample;
    logic signed [SAMP_W-1:0] q_sample;

    modport source (
        output valid, status, i_sample, q_sample,
        input  ready
    );

    modport sink (
        input  valid, status, i_sample, q_sample,
        output ready
    );
endinterface

@@ design/multi_tone_fsk_iq_synthesizer_unit.sv @@
// Multi-tone IQ synthesizer. Load items and start items are taken while the
// sequencer is idle and give no beat. A sample tick scans each tone in turn
// and steps each active tone through phase step, ROM read and accumulate
// states; a tick while the failure flag is set goes straight to the result
// state. The tick time is set by one shared 26 x 26 multiplier, which forms five
// products per active tone (three for the phase step, one each for the cosine
// and sine terms), and by the registered sine ROM that is read twice per tone.
// The input is ready only while the sequencer is idle; a finished beat waits in
// the output register while the next item is taken. There is no clearing pass
// after reset.
`include "multi_tone_fsk_iq_synthesizer_unit_assert.svh"

module multi_tone_fsk_iq_synthesizer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mtfs_in_if.sink                       i_item,
    mtfs_out_if.source                    o_result,
    input  logic                          i_cfg_we,
    input  logic [mtfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mtfs_pkg::CFG_W-1:0]     i_cfg_data
);
    import mtfs_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_SCAN = 11'b000_0000_0010,
        S_MA   = 11'b000_0000_0100,
        S_MB   = 11'b000_0000_1000,
        S_MR   = 11'b000_0001_0000,
        S_PH   = 11'b000_0010_0000,
        S_RS   = 11'b000_0100_0000,
        S_RC   = 11'b000_1000_0000,
        S_AQ   = 11'b001_0000_0000,
        S_AI   = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    // Tone store and capture state.
    logic [FREQ_W-1:0]     r_freq  [NUM_TONES];
    logic [AMPL_W-1:0]     r_ampl  [NUM_TONES];
    logic [PHASE_BITS-1:0] r_phase [NUM_TONES];
    logic [NUM_TONES-1:0]  r_active;
    logic [POS_W-1:0]      r_pos;
    logic [FREQ_W-1:0]     r_center;
    logic                  r_failed_cfg;

    // Sequencer.
    t_state                r_state;
    t_state                n_state;
    logic [TONE_CNT_W-1:0] r_tone;
    logic                  r_plus;
    logic                  r_fail;
    logic [PHASE_BITS-1:0] r_base;

    // Shared multiplier.
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;

    // Sine ROM.
    logic [SAMP_W-1:0]         w_qsine [0:SINE_QTR];
    logic [SAMP_W-1:0]         r_rom_mag;
    logic                      r_rom_neg;
    logic signed [SAMP_W-1:0]  w_sine;
    logic [SINE_ADDR_BITS-1:0] w_sin_addr;
    logic [SINE_ADDR_BITS-1:0] w_rd_addr;
    logic [SINE_ADDR_BITS-2:0] w_rem;
    logic [SINE_ADDR_BITS-2:0] w_fold;

    // Accumulators and result register.
    logic signed [ACC_W-1:0]  r_acc_i;
    logic signed [ACC_W-1:0]  r_acc_q;
    logic signed [ACC_W-1:0]  w_rnd_i;
    logic signed [ACC_W-1:0]  w_rnd_q;
    logic                     r_out_valid;
    logic                     r_out_status;
    logic signed [SAMP_W-1:0] r_out_i;
    logic signed [SAMP_W-1:0] r_out_q;

    logic                    w_accept;
    logic                    w_out_free;
    logic [TONE_IDX_W-1:0]   w_idx;
    logic [TONE_IDX_W-1:0]   w_ld_idx;
    logic signed [FREQ_W:0]  w_diff;
    logic signed [MUL_W-1:0] w_z;
    logic [PHASE_BITS-1:0]   w_quot;
    longint                  w_zadd;
    longint                  w_sadd;
    logic [NUM_TONES-1:0]    w_in_win;

    function automatic logic signed [SAMP_W-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SAMP_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[SAMP_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[SAMP_W-1:0];
        end else begin
            res = v[SAMP_W-1:0];
        end
        return res;
    endfunction

    for (genvar g = 0; g <= SINE_QTR; g++) begin : g_qsine
        assign w_qsine[g] = quarter_sine(g);
    end

    assign i_item.ready      = (r_state == S_IDLE);
    assign w_accept          = i_item.valid && i_item.ready;
    assign w_out_free        = !r_out_valid || o_result.ready;
    assign o_result.valid    = r_out_valid;
    assign o_result.status   = r_out_status;
    assign o_result.i_sample = r_out_i;
    assign o_result.q_sample = r_out_q;

    assign w_idx    = r_tone[TONE_IDX_W-1:0];
    assign w_ld_idx = TONE_IDX_W'(i_item.tone_index);
    assign w_diff   = $signed({1'b0, r_freq[w_idx]}) - $signed({1'b0, r_center});

    // Capture window test for every tone at once.
    always_comb begin
        for (int t = 0; t < NUM_TONES; t++) begin
            w_in_win[t] = (({1'b0, r_freq[t]} + (FREQ_W + 1)'(HALF_WINDOW)) > {1'b0, r_center})
                       && ({1'b0, r_freq[t]} < ({1'b0, r_center} + (FREQ_W + 1)'(HALF_WINDOW)));
        end
    end

    // A silent tone gets no frequency nudge.
    always_comb begin
        if (r_freq[w_idx] == '0) begin
            w_zadd = ZADD_ZERO;
            w_sadd = SADD_ZERO;
        end else if (r_plus) begin
            w_zadd = ZADD_PLUS;
            w_sadd = SADD_PLUS;
        end else begin
            w_zadd = ZADD_MINUS;
            w_sadd = SADD_MINUS;
        end
    end

    assign w_z    = r_prod[MUL_W-1:0] + MUL_W'(w_zadd);
    assign w_quot = PHASE_BITS'(r_prod >>> RECIP_SH);

    // Sine ROM address: the sine in one read, the cosine a quarter turn on.
    assign w_sin_addr = r_phase[w_idx][PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign w_rd_addr  = (r_state == S_RS) ? w_sin_addr
                                          : w_sin_addr + SINE_ADDR_BITS'(SINE_QTR);
    assign w_rem      = w_rd_addr[SINE_ADDR_BITS-2:0];
    assign w_fold     = (w_rem > (SINE_ADDR_BITS - 1)'(SINE_QTR)) ? -w_rem : w_rem;
    assign w_sine     = r_rom_neg ? -$signed(r_rom_mag) : $signed(r_rom_mag);

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MA: begin
                w_mul_a = MUL_W'(w_diff);
                w_mul_b = MUL_W'(STEP_A);
            end
            S_MB: begin
                w_mul_a = MUL_W'(w_diff);
                w_mul_b = MUL_W'(STEP_B);
            end
            S_MR: begin
                w_mul_a = w_z;
                w_mul_b = MUL_W'(RECIP_M);
            end
            S_RC, S_AQ: begin
                w_mul_a = MUL_W'(r_ampl[w_idx]);
                w_mul_b = MUL_W'(w_sine);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_rnd_i = (r_acc_i + ROUND_HALF) >>> 15;
    assign w_rnd_q = (r_acc_q + ROUND_HALF) >>> 15;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_item.mode == MODE_TICK) begin
                    n_state = r_failed_cfg ? S_OUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_tone == TONE_CNT_W'(NUM_TONES)) begin
                    n_state = S_OUT;
                end else if (r_active[w_idx]) begin
                    n_state = S_MA;
                end
            end
            S_MA: n_state = S_MB;
            S_MB: n_state = S_MR;
            S_MR: n_state = S_PH;
            S_PH: n_state = S_RS;
            S_RS: n_state = S_RC;
            S_RC: n_state = S_AQ;
            S_AQ: n_state = S_AI;
            S_AI: n_state = S_SCAN;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        r_prod    <= w_prod;
        r_rom_mag <= w_qsine[w_fold];
        r_rom_neg <= w_rd_addr[SINE_ADDR_BITS-1];
        if (r_state == S_MB) begin
            r_base <= r_prod[PHASE_BITS-1:0] + PHASE_BITS'(w_sadd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tone       <= '0;
            r_plus       <= 1'b1;
            r_fail       <= 1'b0;
            r_center     <= '0;
            r_failed_cfg <= 1'b1;
            r_active     <= '0;
            r_pos        <= '0;
            r_acc_i      <= '0;
            r_acc_q      <= '0;
            r_out_valid  <= 1'b0;
            r_out_status <= 1'b0;
            r_out_i      <= '0;
            r_out_q      <= '0;
            for (int t = 0; t < NUM_TONES; t++) begin
                r_freq[t]  <= '0;
                r_ampl[t]  <= '0;
                r_phase[t] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CENTER: r_center     <= i_cfg_data[FREQ_W-1:0];
                    CFG_FAILED: r_failed_cfg <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // A new beat may take the place of one that leaves in the same cycle.
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_item.mode)
                            MODE_LOAD: begin
                                if (32'(i_item.tone_index) < NUM_TONES) begin
                                    r_freq[w_ld_idx] <= i_item.tone_freq;
                                    r_ampl[w_ld_idx] <= i_item.tone_ampl;
                                end
                            end
                            MODE_START: begin
                                r_active <= w_in_win;
                                r_pos    <= '0;
                                for (int t = 0; t < NUM_TONES; t++) begin
                                    r_phase[t] <= '0;
                                end
                            end
                            MODE_TICK: begin
                                r_tone  <= '0;
                                r_acc_i <= '0;
                                r_acc_q <= '0;
                                r_fail  <= r_failed_cfg;
                                r_plus  <= (r_pos < POS_W'(TOGGLE_PERIOD));
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_tone != TONE_CNT_W'(NUM_TONES) && !r_active[w_idx]) begin
                        r_tone <= r_tone + 1'b1;
                    end
                end
                S_PH: begin
                    r_phase[w_idx] <= r_phase[w_idx] + r_base + w_quot;
                end
                S_AQ: begin
                    r_acc_q <= r_acc_q + $signed(r_prod[ACC_W-1:0]);
                end
                S_AI: begin
                    r_acc_i <= r_acc_i + $signed(r_prod[ACC_W-1:0]);
                    r_tone  <= r_tone + 1'b1;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_status <= r_fail;
                        r_out_i      <= r_fail ? '0 : sat_sample(w_rnd_i);
                        r_out_q      <= r_fail ? '0 : sat_sample(w_rnd_q);
                        // The toggle position only moves on a tick that gave samples.
                        if (!r_fail) begin
                            if (r_pos == POS_W'(2 * TOGGLE_PERIOD - 1)) begin
                                r_pos <= '0;
                            end else begin
                                r_pos <= r_pos + 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `MTFS_ASSERT_NEXT(a_fail_tick_direct,
        w_accept && i_item.mode == MODE_TICK && r_failed_cfg, r_state == S_OUT,
        "failed tick did not go straight to the result stage")
    `MTFS_ASSERT_NOW(a_fail_zero_samples,
        o_result.valid && o_result.status, o_result.i_sample == '0 && o_result.q_sample == '0,
        "failure beat carries non-zero samples")
    `MTFS_ASSERT_NEXT(a_fail_pos_hold,
        r_state == S_OUT && w_out_free && r_fail, $stable(r_pos),
        "sample position moved on a failed tick")
    `MTFS_ASSERT_NOW(a_tone_bound,
        r_state != S_IDLE, r_tone <= TONE_CNT_W'(NUM_TONES),
        "tone counter ran past the last tone")

endmodule
